// File: hdl/lru_ttl_pkg.sv
// Shared types, codes and widths for the LRU cache with time-to-live.
package lru_ttl_pkg;

    localparam int LRU_TTL_MAX_ENTRIES_DEF = 16;

    localparam int OP_W     = 2;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int TTL_W    = 32;
    localparam int TIME_W   = 64;
    localparam int CAP_W    = 5;
    localparam int STATUS_W = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [OP_W-1:0] {
        OP_GET  = 2'd0,
        OP_PUT  = 2'd1,
        OP_TICK = 2'd2,
        OP_NOP  = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STS_MISS      = 3'd0,
        STS_HIT       = 3'd1,
        STS_EXPIRED   = 3'd2,
        STS_UPDATED   = 3'd3,
        STS_INSERTED  = 3'd4,
        STS_EVICTED   = 3'd5,
        STS_TICK_DONE = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_FIND_DRAIN,
        S_DECIDE,
        S_ADJUST,
        S_ADJUST_DRAIN,
        S_WRITE,
        S_RESULT
    } t_state;

    typedef enum logic [1:0] {
        MD_MRU,
        MD_REMOVE,
        MD_INSERT
    } t_mode;

endpackage

// File: hdl/lru_ttl_if.sv
// Request and response channel interfaces of the LRU cache with time-to-live.
interface lru_ttl_req_if;
    import lru_ttl_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic signed [KEY_W-1:0]  lookup_key;
    logic signed [VAL_W-1:0]  put_value;
    logic [TTL_W-1:0]         ttl_ms;

    modport source (output valid, output op, output lookup_key, output put_value,
                    output ttl_ms, input ready);
    modport sink   (input valid, input op, input lookup_key, input put_value,
                    input ttl_ms, output ready);
endinterface

interface lru_ttl_rsp_if;
    import lru_ttl_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [VAL_W-1:0]  read_value;
    logic signed [KEY_W-1:0]  evicted_key;

    modport source (output valid, output status, output read_value, output evicted_key,
                    input ready);
    modport sink   (input valid, input status, input read_value, input evicted_key,
                    output ready);
endinterface

// File: hdl/lru_cache_with_ttl_core.sv
// A get or put runs a find pass, then a decide state; a hit, an insert or an expired get runs an
// adjust pass, and all but the expired get then a write, before the result state. A tick or the
// unused code goes straight to result. Both passes visit one entry per cycle via one memory port.
// Throughput: one request at a time, the next transfer in the cycle after the response is loaded;
// a response still waiting in the output register holds the following one in its result state.
// Reset: store empty, time zero, capacity 16; entry memories stay uncleared behind valid flags.
module lru_cache_with_ttl_core #(
    parameter int MAX_ENTRIES = lru_ttl_pkg::LRU_TTL_MAX_ENTRIES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [lru_ttl_pkg::CAP_W-1:0]  i_cfg_wr_data,
    lru_ttl_req_if.sink                    i_req,
    lru_ttl_rsp_if.source                  o_rsp
);
    import lru_ttl_pkg::*;

    localparam int IW   = $clog2(MAX_ENTRIES);
    localparam int RW   = IW;
    localparam int CNTW = $clog2(MAX_ENTRIES + 1);
    localparam int CAPX = (CNTW > CAP_W) ? CNTW : CAP_W;

    // Control state.
    t_state                r_state, n_state;
    logic [CAP_W-1:0]      r_cap;
    logic [CNTW-1:0]       r_count;
    logic [TIME_W-1:0]     r_time;
    logic [MAX_ENTRIES-1:0] r_valid;
    logic [IW-1:0]         r_idx;
    logic                  r_rd_vld;
    logic [IW-1:0]         r_rd_idx;
    logic                  r_hit, r_lru_fnd, r_free_fnd;
    logic                  r_out_valid;

    // Request payload and scan results.
    t_op                   r_op;
    logic [KEY_W-1:0]      r_key;
    logic [VAL_W-1:0]      r_val;
    logic [TIME_W-1:0]     r_exp_new;
    logic [IW-1:0]         r_hit_idx, r_lru_idx, r_free_idx, r_slot;
    logic [RW-1:0]         r_hit_rank, r_ref_rank;
    logic [TIME_W-1:0]     r_hit_exp;
    logic [VAL_W-1:0]      r_hit_val;
    logic [KEY_W-1:0]      r_lru_key;
    t_mode                 r_mode;
    logic                  r_wr_data;
    t_status               r_res_status, r_out_status;
    logic [VAL_W-1:0]      r_res_rv, r_out_rv;
    logic [KEY_W-1:0]      r_res_ek, r_out_ek;

    // Entry memories and their registered read data.
    logic [KEY_W-1:0]      r_mem_key  [MAX_ENTRIES];
    logic [VAL_W-1:0]      r_mem_val  [MAX_ENTRIES];
    logic [TIME_W-1:0]     r_mem_exp  [MAX_ENTRIES];
    logic [RW-1:0]         r_mem_rank [MAX_ENTRIES];
    logic [KEY_W-1:0]      r_rd_key;
    logic [VAL_W-1:0]      r_rd_val;
    logic [TIME_W-1:0]     r_rd_exp;
    logic [RW-1:0]         r_rd_rank;

    logic                  in_fire, out_load, issue_rd, scan_last;
    logic                  match_phase, adjust_phase, rd_entry_valid;
    logic [CAPX-1:0]       cap_x, cap_eff, count_x;
    logic [CNTW-1:0]       count_m1;
    logic [RW-1:0]         top_rank;
    logic [TIME_W:0]       exp_sum;
    logic [TIME_W-1:0]     exp_sat;
    logic                  expired, evict, ins_ok;
    logic [IW-1:0]         ins_slot;
    logic                  rank_we, data_we;
    logic [IW-1:0]         rank_waddr;
    logic [RW-1:0]         rank_wdata, rank_adj;
    logic                  rank_chg;

    assign in_fire   = i_req.valid && i_req.ready;
    assign scan_last = (r_idx == IW'(MAX_ENTRIES - 1));
    assign rd_entry_valid = r_valid[r_rd_idx];

    // Capacity zero acts as one; anything above the store size acts as the store size.
    assign cap_x   = CAPX'(r_cap);
    assign cap_eff = (cap_x == '0) ? CAPX'(1)
                   : ((cap_x > CAPX'(MAX_ENTRIES)) ? CAPX'(MAX_ENTRIES) : cap_x);
    assign count_x  = CAPX'(r_count);
    assign count_m1 = r_count - CNTW'(1);
    assign top_rank = count_m1[RW-1:0];

    assign exp_sum = {1'b0, r_time} + (TIME_W + 1)'(i_req.ttl_ms);
    assign exp_sat = exp_sum[TIME_W] ? '1 : exp_sum[TIME_W-1:0];

    // Decision terms, valid in the decide state.
    assign expired = (r_time >= r_hit_exp);
    assign evict   = !r_hit && (count_x >= cap_eff) && r_lru_fnd;
    assign ins_ok  = evict || r_free_fnd;
    assign ins_slot = evict ? ((r_free_fnd && (r_free_idx < r_lru_idx)) ? r_free_idx
                                                                         : r_lru_idx)
                            : r_free_idx;

    // Age-rank adjustment for the entry coming back from the memory.
    always_comb begin
        rank_adj = r_rd_rank;
        rank_chg = 1'b0;
        case (r_mode)
            MD_MRU: begin
                if (r_rd_rank < r_ref_rank) begin
                    rank_adj = r_rd_rank + RW'(1);
                    rank_chg = 1'b1;
                end
            end
            MD_REMOVE: begin
                if (r_rd_rank > r_ref_rank) begin
                    rank_adj = r_rd_rank - RW'(1);
                    rank_chg = 1'b1;
                end
            end
            MD_INSERT: begin
                rank_adj = r_rd_rank + RW'(1);
                rank_chg = 1'b1;
            end
            default: begin
                rank_adj = r_rd_rank;
                rank_chg = 1'b0;
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if ((t_op'(i_req.op) == OP_GET) || (t_op'(i_req.op) == OP_PUT)) begin
                        n_state = S_FIND;
                    end else begin
                        n_state = S_RESULT;
                    end
                end
            end
            S_FIND: begin
                if (scan_last) begin
                    n_state = S_FIND_DRAIN;
                end
            end
            S_FIND_DRAIN: n_state = S_DECIDE;
            S_DECIDE: begin
                if (r_op == OP_GET) begin
                    n_state = r_hit ? S_ADJUST : S_RESULT;
                end else begin
                    n_state = (r_hit || ins_ok) ? S_ADJUST : S_RESULT;
                end
            end
            S_ADJUST: begin
                if (scan_last) begin
                    n_state = S_ADJUST_DRAIN;
                end
            end
            S_ADJUST_DRAIN: n_state = (r_mode == MD_REMOVE) ? S_RESULT : S_WRITE;
            S_WRITE:        n_state = S_RESULT;
            S_RESULT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        i_req.ready  = (r_state == S_IDLE);
        issue_rd     = (r_state == S_FIND) || (r_state == S_ADJUST);
        match_phase  = r_rd_vld && ((r_state == S_FIND) || (r_state == S_FIND_DRAIN));
        adjust_phase = r_rd_vld && ((r_state == S_ADJUST) || (r_state == S_ADJUST_DRAIN));
        out_load     = (r_state == S_RESULT) && (!r_out_valid || o_rsp.ready);
        data_we      = (r_state == S_WRITE) && r_wr_data;
        rank_we      = (r_state == S_WRITE) || (adjust_phase && rd_entry_valid && rank_chg);
        rank_waddr   = (r_state == S_WRITE) ? r_slot : r_rd_idx;
        rank_wdata   = (r_state == S_WRITE) ? '0 : rank_adj;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.read_value  = r_out_rv;
    assign o_rsp.evicted_key = r_out_ek;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= CAP_RESET;
            r_count     <= '0;
            r_time      <= '0;
            r_valid     <= '0;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_hit       <= 1'b0;
            r_lru_fnd   <= 1'b0;
            r_free_fnd  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= issue_rd;
            r_idx    <= issue_rd ? (r_idx + IW'(1)) : '0;

            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end

            if (in_fire) begin
                r_hit      <= 1'b0;
                r_lru_fnd  <= 1'b0;
                r_free_fnd <= 1'b0;
                if ((t_op'(i_req.op) == OP_TICK) && (r_time != '1)) begin
                    r_time <= r_time + TIME_W'(1);
                end
            end

            if (match_phase) begin
                if (rd_entry_valid && (r_rd_key == r_key)) begin
                    r_hit <= 1'b1;
                end
                if (rd_entry_valid && (r_rd_rank == top_rank)) begin
                    r_lru_fnd <= 1'b1;
                end
                if (!rd_entry_valid) begin
                    r_free_fnd <= 1'b1;
                end
            end

            if (r_state == S_DECIDE) begin
                if ((r_op == OP_GET) && r_hit && expired) begin
                    r_valid[r_hit_idx] <= 1'b0;
                    r_count <= r_count - CNTW'(1);
                end else if ((r_op == OP_PUT) && evict) begin
                    r_valid[r_lru_idx] <= 1'b0;
                    r_count <= r_count - CNTW'(1);
                end
            end

            if ((r_state == S_WRITE) && (r_mode == MD_INSERT)) begin
                r_valid[r_slot] <= 1'b1;
                r_count <= r_count + CNTW'(1);
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_idx;

        if (in_fire) begin
            r_op         <= t_op'(i_req.op);
            r_key        <= i_req.lookup_key;
            r_val        <= i_req.put_value;
            r_exp_new    <= exp_sat;
            r_res_status <= (t_op'(i_req.op) == OP_TICK) ? STS_TICK_DONE : STS_MISS;
            r_res_rv     <= '0;
            r_res_ek     <= '0;
        end

        // Keys are unique among live entries, so the first match is the only one.
        if (match_phase) begin
            if (rd_entry_valid && (r_rd_key == r_key) && !r_hit) begin
                r_hit_idx  <= r_rd_idx;
                r_hit_rank <= r_rd_rank;
                r_hit_exp  <= r_rd_exp;
                r_hit_val  <= r_rd_val;
            end
            if (rd_entry_valid && (r_rd_rank == top_rank) && !r_lru_fnd) begin
                r_lru_idx <= r_rd_idx;
                r_lru_key <= r_rd_key;
            end
            if (!rd_entry_valid && !r_free_fnd) begin
                r_free_idx <= r_rd_idx;
            end
        end

        if (r_state == S_DECIDE) begin
            r_ref_rank <= r_hit_rank;
            r_slot     <= r_hit_idx;
            r_wr_data  <= 1'b0;
            r_mode     <= MD_MRU;
            if (r_op == OP_GET) begin
                if (r_hit && expired) begin
                    r_mode       <= MD_REMOVE;
                    r_res_status <= STS_EXPIRED;
                end else if (r_hit) begin
                    r_res_status <= STS_HIT;
                    r_res_rv     <= r_hit_val;
                end else begin
                    r_res_status <= STS_MISS;
                end
            end else if (r_hit) begin
                r_wr_data    <= 1'b1;
                r_res_status <= STS_UPDATED;
            end else begin
                r_mode    <= MD_INSERT;
                r_slot    <= ins_slot;
                r_wr_data <= 1'b1;
                if (evict) begin
                    r_res_status <= STS_EVICTED;
                    r_res_ek     <= r_lru_key;
                end else begin
                    r_res_status <= STS_INSERTED;
                end
            end
        end

        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_rv     <= r_res_rv;
            r_out_ek     <= r_res_ek;
        end
    end

    // Entry memories: one write and one read address per cycle.
    always_ff @(posedge i_clk) begin
        if (rank_we) begin
            r_mem_rank[rank_waddr] <= rank_wdata;
        end
        if (data_we) begin
            r_mem_key[r_slot] <= r_key;
            r_mem_val[r_slot] <= r_val;
            r_mem_exp[r_slot] <= r_exp_new;
        end
        r_rd_key  <= r_mem_key[r_idx];
        r_rd_val  <= r_mem_val[r_idx];
        r_rd_exp  <= r_mem_exp[r_idx];
        r_rd_rank <= r_mem_rank[r_idx];
    end

    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_count) == 32'($countones(r_valid))))
        else $error("entry count disagrees with the number of live entries");

    a_insert_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WRITE) && (r_mode == MD_INSERT)) |-> !r_valid[r_slot])
        else $error("insert targets a slot that still holds a live entry");

    a_response_from_result_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_RESULT))
        else $error("response presented without passing through the result state");

endmodule

// File: tb/lru_ttl_reply_check.sv
`timescale 1ns / 1ps
// Reply checker for the LRU cache with time-to-live: tracks the cache contents and checks each reply.
module lru_ttl_reply_check #(
    parameter int MAX_ENTRIES = lru_ttl_pkg::LRU_TTL_MAX_ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [lru_ttl_pkg::CAP_W-1:0] i_cfg_wr_data,
    lru_ttl_req_if                        i_req_mon,
    lru_ttl_rsp_if                        i_rsp_mon,
    output int                            o_outstanding,
    output int                            o_fail_count
);
    import lru_ttl_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct {
        t_status           status;
        logic [VAL_W-1:0]  read_value;
        logic [KEY_W-1:0]  evicted_key;
    } t_reply;

    logic              slot_used   [MAX_ENTRIES];
    logic [KEY_W-1:0]  slot_key    [MAX_ENTRIES];
    logic [VAL_W-1:0]  slot_value  [MAX_ENTRIES];
    logic [TIME_W-1:0] slot_expiry [MAX_ENTRIES];
    int unsigned       slot_rank   [MAX_ENTRIES];
    int unsigned       used_count;
    logic [TIME_W-1:0] clock_ms;
    logic [CAP_W-1:0]  capacity;
    t_reply            replies_due [$];
    int                fails = 0;

    function automatic int find_key(input logic [KEY_W-1:0] key);
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (slot_used[i] && slot_key[i] == key) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Rank 0 is the most recent entry; everything younger than the slot ages by one.
    function automatic void promote(input int slot);
        int unsigned r;
        r = slot_rank[slot];
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (slot_used[i] && slot_rank[i] < r) begin
                slot_rank[i]++;
            end
        end
        slot_rank[slot] = 0;
    endfunction

    function automatic void drop_entry(input int slot);
        int unsigned r;
        r = slot_rank[slot];
        slot_used[slot] = 1'b0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (slot_used[i] && slot_rank[i] > r) begin
                slot_rank[i]--;
            end
        end
        if (used_count > 0) begin
            used_count--;
        end
    endfunction

    function automatic logic [TIME_W-1:0] expiry_after(input logic [TTL_W-1:0] ttl);
        logic [TIME_W:0] sum;
        sum = {1'b0, clock_ms} + ttl;
        return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    endfunction

    function automatic t_reply cache_access(input t_op op, input logic [KEY_W-1:0] key,
                                            input logic [VAL_W-1:0] val,
                                            input logic [TTL_W-1:0] ttl);
        t_reply      reply;
        int          slot;
        int unsigned cap;
        reply.status      = STS_MISS;
        reply.read_value  = '0;
        reply.evicted_key = '0;
        cap = (capacity == 0) ? 1 : ((capacity > MAX_ENTRIES) ? MAX_ENTRIES : capacity);
        case (op)
            OP_GET: begin
                slot = find_key(key);
                if (slot < 0) begin
                    reply.status = STS_MISS;
                end else if (clock_ms >= slot_expiry[slot]) begin
                    drop_entry(slot);
                    reply.status = STS_EXPIRED;
                end else begin
                    promote(slot);
                    reply.read_value = slot_value[slot];
                    reply.status     = STS_HIT;
                end
            end
            OP_PUT: begin
                slot = find_key(key);
                if (slot >= 0) begin
                    slot_value[slot]  = val;
                    slot_expiry[slot] = expiry_after(ttl);
                    promote(slot);
                    reply.status = STS_UPDATED;
                end else begin
                    reply.status = STS_INSERTED;
                    // Only the least recent entry goes, even if the store is still over capacity.
                    if (used_count >= cap) begin
                        for (int i = 0; i < MAX_ENTRIES; i++) begin
                            if (slot_used[i] && slot_rank[i] == used_count - 1) begin
                                reply.evicted_key = slot_key[i];
                                reply.status      = STS_EVICTED;
                                drop_entry(i);
                                break;
                            end
                        end
                    end
                    slot = -1;
                    for (int i = 0; i < MAX_ENTRIES; i++) begin
                        if (!slot_used[i]) begin
                            slot = i;
                            break;
                        end
                    end
                    if (slot >= 0) begin
                        for (int i = 0; i < MAX_ENTRIES; i++) begin
                            if (slot_used[i]) begin
                                slot_rank[i]++;
                            end
                        end
                        slot_used[slot]   = 1'b1;
                        slot_key[slot]    = key;
                        slot_value[slot]  = val;
                        slot_expiry[slot] = expiry_after(ttl);
                        slot_rank[slot]   = 0;
                        used_count++;
                    end
                end
            end
            OP_TICK: begin
                if (clock_ms != '1) begin
                    clock_ms++;
                end
                reply.status = STS_TICK_DONE;
            end
            default: begin
            end
        endcase
        return reply;
    endfunction

    always @(posedge i_clk) begin : observe
        t_reply want;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                slot_used[i] = 1'b0;
            end
            used_count = 0;
            clock_ms   = '0;
            capacity   = CAP_RESET;
            replies_due.delete();
        end else begin
            if (i_cfg_wr_en) begin
                capacity = i_cfg_wr_data;
            end
            // Replies are taken before requests so a reply never meets its own request.
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                if (replies_due.size() == 0) begin
                    if (fails < REPORT_LIMIT) begin
                        $display("unexpected reply: status %0d read_value %h evicted_key %h",
                                 i_rsp_mon.status, i_rsp_mon.read_value,
                                 i_rsp_mon.evicted_key);
                    end
                    fails++;
                end else begin
                    want = replies_due.pop_front();
                    if (i_rsp_mon.status !== want.status
                            || i_rsp_mon.read_value !== want.read_value
                            || i_rsp_mon.evicted_key !== want.evicted_key) begin
                        if (fails < REPORT_LIMIT) begin
                            $display({"reply mismatch: status exp %0d got %0d, ",
                                      "read_value exp %h got %h, evicted_key exp %h got %h"},
                                     want.status, i_rsp_mon.status,
                                     want.read_value, i_rsp_mon.read_value,
                                     want.evicted_key, i_rsp_mon.evicted_key);
                        end
                        fails++;
                    end
                end
            end
            if (i_req_mon.valid && i_req_mon.ready) begin
                replies_due.push_back(cache_access(t_op'(i_req_mon.op), i_req_mon.lookup_key,
                                                   i_req_mon.put_value, i_req_mon.ttl_ms));
            end
        end
        o_outstanding <= replies_due.size();
        o_fail_count  <= fails;
    end

endmodule

// File: tb/lru_cache_with_ttl_core_test.sv
`timescale 1ns / 1ps
// Top of the LRU cache with time-to-live regression: clock, reset, request traffic and verdict.
module lru_cache_with_ttl_core_test;
    import lru_ttl_pkg::*;

    localparam int MAX_ENTRIES   = LRU_TTL_MAX_ENTRIES_DEF;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int HOLD_CYCLES   = 600;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 316;
    localparam int SETTLE_CYCLES = 2 * MAX_ENTRIES + 10;
    localparam int KEY_POOL      = 24;
    // Capacity per random phase, phase 0 in the low bits: above the maximum, small, zero,
    // the maximum, small again and one.
    localparam logic [PHASES*CAP_W-1:0] PHASE_CAPS = {5'd1, 5'd5, 5'd16, 5'd0, 5'd3, 5'd31};

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CAP_W-1:0] cfg_wr_data;
    int               outstanding;
    int               fail_count;
    int               req_idle_pct;
    int               rsp_idle_pct;
    int               hold_asks;
    int               cycle_count = 0;
    logic [KEY_W-1:0] key_pool [KEY_POOL];

    lru_ttl_req_if req_ch ();
    lru_ttl_rsp_if rsp_ch ();

    lru_cache_with_ttl_core #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) uut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_req        (req_ch),
        .o_rsp        (rsp_ch)
    );

    lru_ttl_reply_check #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) reply_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_req_mon    (req_ch),
        .i_rsp_mon    (rsp_ch),
        .o_outstanding(outstanding),
        .o_fail_count (fail_count)
    );

    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("lru_cache_with_ttl_core regression: fail");
            $finish;
        end
    end

    // Reply side: random back-pressure, plus a long hold-off whenever the traffic asks for one.
    initial begin : reply_sink
        int holds_taken;
        int stall_left;
        holds_taken  = 0;
        stall_left   = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_asks != holds_taken) begin
                holds_taken = hold_asks;
                stall_left  = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
            end
        end
    end

    task automatic offer_request(input t_op op, input logic [KEY_W-1:0] key,
                                 input logic [VAL_W-1:0] val, input logic [TTL_W-1:0] ttl);
        while ($urandom_range(99) < req_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.op         <= op;
        req_ch.lookup_key <= key;
        req_ch.put_value  <= val;
        req_ch.ttl_ms     <= ttl;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    task automatic wait_for_replies();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin : traffic
        t_op              op;
        int               pick;
        logic [KEY_W-1:0] key;
        logic [TTL_W-1:0] ttl;
        req_ch.valid      = 1'b0;
        req_ch.op         = OP_NOP;
        req_ch.lookup_key = '0;
        req_ch.put_value  = '0;
        req_ch.ttl_ms     = '0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = '0;
        rst_n             = 1'b0;
        hold_asks         = 0;
        req_idle_pct      = 37;
        rsp_idle_pct      = 81;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < KEY_POOL; i++) begin
            key_pool[i] = $urandom;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty store, extreme keys and values, zero and maximum lifetimes.
        offer_request(OP_GET, 32'h0000_0000, 32'h0, 32'h0);
        offer_request(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        offer_request(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        offer_request(OP_GET, 32'h8000_0000, 32'h0, 32'h0);
        offer_request(OP_GET, 32'h7FFF_FFFF, 32'h0, 32'h0);
        // Rewriting a live entry, then letting it run out exactly at its expiry.
        offer_request(OP_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd2);
        offer_request(OP_TICK, 32'h0, 32'h0, 32'h0);
        offer_request(OP_GET, 32'h7FFF_FFFF, 32'h0, 32'h0);
        offer_request(OP_TICK, 32'h0, 32'h0, 32'h0);
        offer_request(OP_GET, 32'h7FFF_FFFF, 32'h0, 32'h0);
        // A put on an entry that has expired but was never looked up updates it in place.
        offer_request(OP_PUT, 32'd5, 32'h0, 32'd1);
        offer_request(OP_TICK, 32'h0, 32'h0, 32'h0);
        offer_request(OP_PUT, 32'd5, 32'h55AA_55AA, 32'd3);
        offer_request(OP_GET, 32'd5, 32'h0, 32'h0);
        offer_request(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_request(OP_PUT, 32'h0000_0000, 32'hAAAA_AAAA, 32'h8000_0000);
        offer_request(OP_GET, 32'hFFFF_FFFF, 32'h0, 32'h0);
        // Capacity dropped below the count: each new key evicts just one entry.
        wait_for_replies();
        write_capacity(5'd1);
        offer_request(OP_PUT, 32'h0000_1234, 32'h1111_1111, 32'd100);
        offer_request(OP_PUT, 32'h0000_4321, 32'h2222_2222, 32'd100);
        offer_request(OP_GET, 32'h0000_1234, 32'h0, 32'h0);
        offer_request(OP_GET, 32'h0000_0000, 32'h0, 32'h0);

        for (int p = 0; p < PHASES; p++) begin
            wait_for_replies();
            write_capacity(PHASE_CAPS[p*CAP_W +: CAP_W]);
            req_idle_pct  = (p < 2) ? 37 : ((p < 4) ? 81 : 0);
            rsp_idle_pct <= (p < 2) ? 81 : ((p < 4) ? 37 : 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 1 && n == 60) begin
                    hold_asks <= hold_asks + 1;
                end
                pick = $urandom_range(99);
                if (pick < 45) begin
                    op = OP_GET;
                end else if (pick < 80) begin
                    op = OP_PUT;
                end else if (pick < 97) begin
                    op = OP_TICK;
                end else begin
                    op = OP_NOP;
                end
                // Mostly a small key set so gets hit and puts update; now and then a fresh key.
                key = ($urandom_range(99) < 88) ? key_pool[$urandom_range(KEY_POOL - 1)]
                                                : $urandom;
                pick = $urandom_range(99);
                if (pick < 40) begin
                    ttl = $urandom_range(20);
                end else if (pick < 70) begin
                    ttl = $urandom_range(200);
                end else if (pick < 80) begin
                    ttl = '1;
                end else begin
                    ttl = $urandom;
                end
                offer_request(op, key, $urandom, ttl);
            end
        end

        wait_for_replies();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("lru_cache_with_ttl_core regression: pass");
        end else begin
            $display("lru_cache_with_ttl_core regression: fail");
        end
        $finish;
    end

endmodule
